### hw/rtl/gfv_pkg.sv
// Shared types, codes and constants for the GNSS fix validity gate.
`timescale 1ns / 1ps

package gfv_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		CMD_GGA   = 2'd0,
		CMD_RMC   = 2'd1,
		CMD_CHECK = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Verdict codes, highest priority refusal first
	typedef enum logic [2:0] {
		REASON_OK       = 3'd0,
		REASON_NO_RMC   = 3'd1,
		REASON_NO_GGA   = 3'd2,
		REASON_STALE    = 3'd3,
		REASON_NO_SOLN  = 3'd4,
		REASON_NO_DATE  = 3'd5,
		REASON_JUMP     = 3'd6
	} reason_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_MAX_AGE_MS   = 3'd0;
	localparam logic [2:0] CFG_MAX_LAT_STEP = 3'd1;
	localparam logic [2:0] CFG_MAX_LON_STEP = 3'd2;
	localparam logic [2:0] CFG_QUALITY_MIN  = 3'd3;
	localparam logic [2:0] CFG_QUALITY_MAX  = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 31;
	localparam int IN_DATA_W   = 104;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = 40;

	// Reset values of the configuration registers
	localparam logic [15:0] MAX_AGE_MS_RST   = 16'd2000;
	localparam logic [29:0] MAX_LAT_STEP_RST = 30'd10000000;
	localparam logic [30:0] MAX_LON_STEP_RST = 31'd10000000;
	localparam logic [3:0]  QUALITY_MIN_RST  = 4'd1;
	localparam logic [3:0]  QUALITY_MAX_RST  = 4'd5;

	// Longitude wrap: one full turn and half a turn in deg*1e7
	localparam logic signed [33:0] LON_TURN = 34'sd3600000000;
	localparam logic signed [33:0] LON_HALF = 34'sd1800000000;

	typedef struct packed {
		logic [15:0] max_age_ms;
		logic [29:0] max_lat_step;
		logic [30:0] max_lon_step;
		logic [3:0]  quality_min;
		logic [3:0]  quality_max;
	} cfg_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [31:0]        now_ms;
		logic [3:0]         gga_quality;
		logic               alt_valid;
		logic               rmc_fix;
		logic               rmc_date;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
	} item_t;

	typedef struct packed {
		reason_t     reason;
		logic [31:0] reject_count;
	} result_t;

endpackage

### hw/rtl/gfv_jump_check.sv
// Position step check: latitude and wrapped longitude distance against limits.
`timescale 1ns / 1ps

module gfv_jump_check (
	input  logic signed [30:0] lat,
	input  logic signed [31:0] lon,
	input  logic signed [30:0] ref_lat,
	input  logic signed [31:0] ref_lon,
	input  logic [29:0]        max_lat_step,
	input  logic [30:0]        max_lon_step,
	output logic               too_far
);

	logic signed [31:0] lat_diff;
	logic [31:0]        lat_mag;
	logic signed [33:0] lon_diff;
	logic signed [33:0] lon_wrap;
	logic [33:0]        lon_mag;

	// Latitude: exact signed step, no wrap
	assign lat_diff = $signed({lat[30], lat}) - $signed({ref_lat[30], ref_lat});
	assign lat_mag  = lat_diff[31] ? 32'(-lat_diff) : 32'(lat_diff);

	// Longitude: one correction brings any 32-bit difference into the half-open turn
	assign lon_diff = $signed({{2{lon[31]}}, lon}) - $signed({{2{ref_lon[31]}}, ref_lon});

	always_comb begin
		if (lon_diff >= gfv_pkg::LON_HALF) begin
			lon_wrap = lon_diff - gfv_pkg::LON_TURN;
		end else if (lon_diff < -gfv_pkg::LON_HALF) begin
			lon_wrap = lon_diff + gfv_pkg::LON_TURN;
		end else begin
			lon_wrap = lon_diff;
		end
	end

	assign lon_mag = lon_wrap[33] ? 34'(-lon_wrap) : 34'(lon_wrap);

	assign too_far = (lat_mag > {2'b00, max_lat_step}) ||
	                 (lon_mag > {3'b000, max_lon_step});

endmodule

### hw/rtl/gfv_core.sv
// Fix state registers, per-item update and the check verdict with run counter.
`timescale 1ns / 1ps

module gfv_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  gfv_pkg::item_t   item,
	input  gfv_pkg::cfg_t    cfg,
	output gfv_pkg::result_t result
);

	logic               rmc_heard_q;
	logic               gga_heard_q;
	logic               rmc_ok_q;
	logic               gga_ok_q;
	logic               date_ok_q;
	logic               jump_seen_q;
	logic               have_ref_q;
	logic [31:0]        rmc_time_q;
	logic [31:0]        gga_time_q;
	logic signed [30:0] ref_lat_q;
	logic signed [31:0] ref_lon_q;
	gfv_pkg::reason_t   last_reason_q;
	logic [31:0]        refusal_runs_q;

	logic               too_far;
	logic               gga_good;
	logic [31:0]        rmc_age;
	logic [31:0]        gga_age;
	logic               stale;
	gfv_pkg::reason_t   reason;
	logic               new_run;
	logic [31:0]        runs_nx;

	gfv_jump_check u_jump (
		.lat          (item.lat),
		.lon          (item.lon),
		.ref_lat      (ref_lat_q),
		.ref_lon      (ref_lon_q),
		.max_lat_step (cfg.max_lat_step),
		.max_lon_step (cfg.max_lon_step),
		.too_far      (too_far)
	);

	// Empty band (min above max) accepts nothing
	assign gga_good = (item.gga_quality >= cfg.quality_min) &&
	                  (item.gga_quality <= cfg.quality_max) && item.alt_valid;

	// Ages modulo 2^32
	assign rmc_age = item.now_ms - rmc_time_q;
	assign gga_age = item.now_ms - gga_time_q;
	assign stale   = (rmc_age > {16'h0000, cfg.max_age_ms}) ||
	                 (gga_age > {16'h0000, cfg.max_age_ms});

	always_comb begin
		if (!rmc_heard_q) begin
			reason = gfv_pkg::REASON_NO_RMC;
		end else if (!gga_heard_q) begin
			reason = gfv_pkg::REASON_NO_GGA;
		end else if (stale) begin
			reason = gfv_pkg::REASON_STALE;
		end else if (!rmc_ok_q || !gga_ok_q) begin
			reason = gfv_pkg::REASON_NO_SOLN;
		end else if (!date_ok_q) begin
			reason = gfv_pkg::REASON_NO_DATE;
		end else if (jump_seen_q) begin
			reason = gfv_pkg::REASON_JUMP;
		end else begin
			reason = gfv_pkg::REASON_OK;
		end
	end

	// A refusal opens a new run only when it differs from the last verdict
	assign new_run = (reason != gfv_pkg::REASON_OK) && (reason != last_reason_q);
	assign runs_nx = new_run ? refusal_runs_q + 32'd1 : refusal_runs_q;

	always_comb begin
		result.reason       = reason;
		result.reject_count = runs_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmc_heard_q    <= 1'b0;
			gga_heard_q    <= 1'b0;
			rmc_ok_q       <= 1'b0;
			gga_ok_q       <= 1'b0;
			date_ok_q      <= 1'b0;
			jump_seen_q    <= 1'b0;
			have_ref_q     <= 1'b0;
			rmc_time_q     <= '0;
			gga_time_q     <= '0;
			ref_lat_q      <= '0;
			ref_lon_q      <= '0;
			last_reason_q  <= gfv_pkg::REASON_OK;
			refusal_runs_q <= '0;
		end else if (fire) begin
			case (item.cmd)
				gfv_pkg::CMD_GGA: begin
					gga_heard_q <= 1'b1;
					gga_time_q  <= item.now_ms;
					gga_ok_q    <= gga_good;
				end
				gfv_pkg::CMD_RMC: begin
					rmc_heard_q <= 1'b1;
					rmc_time_q  <= item.now_ms;
					rmc_ok_q    <= item.rmc_fix;
					date_ok_q   <= item.rmc_date;
					if (item.rmc_fix) begin
						jump_seen_q <= have_ref_q && too_far;
						ref_lat_q   <= item.lat;
						ref_lon_q   <= item.lon;
						have_ref_q  <= 1'b1;
					end else begin
						jump_seen_q <= 1'b0;
						have_ref_q  <= 1'b0;
					end
				end
				gfv_pkg::CMD_CHECK: begin
					last_reason_q  <= reason;
					refusal_runs_q <= runs_nx;
				end
				gfv_pkg::CMD_CLEAR: begin
					rmc_heard_q <= 1'b0;
					gga_heard_q <= 1'b0;
					rmc_ok_q    <= 1'b0;
					gga_ok_q    <= 1'b0;
					date_ok_q   <= 1'b0;
					jump_seen_q <= 1'b0;
					have_ref_q  <= 1'b0;
				end
				default: begin
					last_reason_q <= last_reason_q;
				end
			endcase
		end
	end

endmodule

### hw/rtl/gnss_fix_validity_gate.sv
// Top level of the GNSS fix validity gate: ports, config, input and result registers.
//
// Usage
//  - Input stream (s_axis_*): one transaction per event. tuser holds the kind
//    (GGA heard, RMC heard, check, clear flags); tdata holds the time stamp,
//    the GGA quality and altitude flag, the RMC fix and date flags and the
//    RMC position.
//  - Output stream (m_axis_*): one transaction per check only, carrying the
//    verdict and the count of distinct refusal runs. Other kinds give nothing.
//  - Config port: cfg_we writes cfg_data into the register cfg_index on the
//    rising edge; indexes beyond the list are ignored. Write only when idle.
//  - Path: a check accepted into the input register goes through the verdict
//    logic straight into the result register; a stalled result can hold it.
//  - Throughput: one transaction per cycle unless a check stalls; all per-item
//    work is one short layer of subtract/compare logic on the state registers.
//  - Stall: a check waits in the input register while an untaken result
//    sits in the output register; s_axis_tready drops only then. GGA, RMC and
//    clear transactions keep flowing past a stalled result.
//  - Reset (arst_n low): flags, times, reference, run counter and the valid
//    flags of both register stages clear; config returns to its defaults.
`timescale 1ns / 1ps

module gnss_fix_validity_gate (
	input  logic                               clk,
	input  logic                               arst_n,
	// now_ms[31:0], gga_quality[35:32], alt_valid[36], rmc_fix[37],
	// rmc_date[38], lat[69:39], lon[101:70], zero pad[103:102]
	input  logic [gfv_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// cmd[1:0]
	input  logic [gfv_pkg::IN_USER_W-1:0]      s_axis_tuser,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// reason[2:0], reject_count[34:3], zero pad[39:35]
	output logic [gfv_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic                               cfg_we,
	input  logic [gfv_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gfv_pkg::CFG_DATA_W-1:0]     cfg_data
);

	gfv_pkg::cfg_t    cfg_q;
	gfv_pkg::item_t   item_in;
	gfv_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             fire_s1;
	logic             is_check_s1;
	gfv_pkg::result_t result;
	gfv_pkg::result_t result_q;
	logic             out_valid_q;

	// Configuration registers, written one at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_age_ms   <= gfv_pkg::MAX_AGE_MS_RST;
			cfg_q.max_lat_step <= gfv_pkg::MAX_LAT_STEP_RST;
			cfg_q.max_lon_step <= gfv_pkg::MAX_LON_STEP_RST;
			cfg_q.quality_min  <= gfv_pkg::QUALITY_MIN_RST;
			cfg_q.quality_max  <= gfv_pkg::QUALITY_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gfv_pkg::CFG_MAX_AGE_MS:   cfg_q.max_age_ms   <= cfg_data[15:0];
				gfv_pkg::CFG_MAX_LAT_STEP: cfg_q.max_lat_step <= cfg_data[29:0];
				gfv_pkg::CFG_MAX_LON_STEP: cfg_q.max_lon_step <= cfg_data[30:0];
				gfv_pkg::CFG_QUALITY_MIN:  cfg_q.quality_min  <= cfg_data[3:0];
				gfv_pkg::CFG_QUALITY_MAX:  cfg_q.quality_max  <= cfg_data[3:0];
				default:                   cfg_q              <= cfg_q;
			endcase
		end
	end

	// Unpack the input transaction
	always_comb begin
		item_in.cmd         = gfv_pkg::cmd_t'(s_axis_tuser);
		item_in.now_ms      = s_axis_tdata[31:0];
		item_in.gga_quality = s_axis_tdata[35:32];
		item_in.alt_valid   = s_axis_tdata[36];
		item_in.rmc_fix     = s_axis_tdata[37];
		item_in.rmc_date    = s_axis_tdata[38];
		item_in.lat         = $signed(s_axis_tdata[69:39]);
		item_in.lon         = $signed(s_axis_tdata[101:70]);
	end

	// The held item moves on unless it is a check with nowhere to put its result
	assign is_check_s1   = (item_s1.cmd == gfv_pkg::CMD_CHECK);
	assign fire_s1       = valid_s1 && (!is_check_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

	gfv_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && is_check_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_check_s1) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, result_q.reject_count, result_q.reason};

endmodule

### hw/rtl/gfv_checker.sv
// Port-level checker for the GNSS fix validity gate, bound to the top level.
`timescale 1ns / 1ps

module gfv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic [gfv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready
);

	// A held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or vanished while stalled");

	// Input back-pressure only ever comes from a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a stalled result");

	// The unused verdict code never appears
	a_reason_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= gfv_pkg::REASON_JUMP)
		else $error("verdict code out of range");

	// A cycle in reset leaves the result register empty
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid after reset");

endmodule

bind gnss_fix_validity_gate gfv_checker u_gfv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
